// ----- design/rtea_pkg.sv -----
// Shared types, constants and the round mixing function of the RTEA-style block cipher.
// No dependencies; used by rtea_stage and rtea_block_cipher_64_top.
package rtea_pkg;

    localparam int HALF_W     = 32;
    localparam int BLOCK_W    = 64;
    localparam int NUM_STAGES = 64;           // one pipeline stage per round, long-key count
    localparam int RND_W      = 6;            // round number width
    localparam int CFG_IDX_W  = 3;

    // Last round number of each key mode and the short-mode round count
    localparam logic [RND_W-1:0] LAST_RND_LONG  = 6'd63;
    localparam logic [RND_W-1:0] LAST_RND_SHORT = 6'd47;
    localparam logic [RND_W-1:0] ROUNDS_SHORT   = 6'd48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_67 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd4;

    // Opcodes
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    // Item carried down the pipeline
    typedef struct packed {
        logic              op;
        logic [HALF_W-1:0] a;
        logic [HALF_W-1:0] b;
    } t_item;

    // Four 64-bit key registers, each holding two key words (even word high)
    typedef logic [3:0][BLOCK_W-1:0] t_key_regs;

    // f(h) = h + ((h << 6) ^ (h >> 8))
    function automatic logic [HALF_W-1:0] mix(input logic [HALF_W-1:0] h);
        logic [HALF_W-1:0] m;
        begin
            m   = (h << 6) ^ (h >> 8);
            mix = h + m;
        end
    endfunction

endpackage

// ----- design/rtea_stage.sv -----
// One round stage of the cipher pipeline: round logic followed by the item register.
// Depends on rtea_pkg.
module rtea_stage
    import rtea_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,        // stage register may load
    input  logic [RND_W-1:0] i_stage,     // fixed position of this stage
    input  logic             i_long_mode,
    input  t_key_regs        i_keys,
    input  logic             i_vld,
    input  t_item            i_item,
    output logic             o_vld,
    output t_item            o_item
);

    logic             r_vld;
    t_item            r_item;
    t_item            n_item;
    logic [RND_W-1:0] last_rnd;
    logic [RND_W-1:0] rnd;
    logic             active;
    logic [2:0]       key_idx;
    logic [HALF_W-1:0] key_word;
    logic [HALF_W-1:0] src;
    logic [HALF_W-1:0] dst;
    logic [HALF_W-1:0] delta;
    logic [HALF_W-1:0] upd;

    // Round number handled here: forward for encrypt, reversed for decrypt
    assign last_rnd = i_long_mode ? LAST_RND_LONG : LAST_RND_SHORT;
    assign rnd      = (i_item.op == OP_DEC) ? (last_rnd - i_stage) : i_stage;
    // Short-key mode passes the item through the trailing stages
    assign active   = i_long_mode || (i_stage < ROUNDS_SHORT);

    // Key word select: round mod 8 or mod 4
    assign key_idx  = rnd[2:0] & {i_long_mode, 2'b11};
    assign key_word = key_idx[0] ? i_keys[key_idx[2:1]][HALF_W-1:0]
                                 : i_keys[key_idx[2:1]][BLOCK_W-1:HALF_W];

    // Even rounds update b from a, odd rounds update a from b
    assign src   = rnd[0] ? i_item.b : i_item.a;
    assign dst   = rnd[0] ? i_item.a : i_item.b;
    assign delta = mix(src) + key_word + {{(HALF_W-RND_W){1'b0}}, rnd};
    assign upd   = (i_item.op == OP_DEC) ? (dst - delta) : (dst + delta);

    always_comb begin
        n_item = i_item;
        if (active) begin
            if (rnd[0]) begin
                n_item.a = upd;
            end else begin
                n_item.b = upd;
            end
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// ----- design/rtea_block_cipher_64_top.sv -----
// Top level of the RTEA-style 64-bit block cipher: config registers and the round pipeline.
// Depends on rtea_pkg and rtea_stage.
//
// Pipelined block cipher: one 64-bit block (with an encrypt/decrypt opcode) is accepted
// every cycle unless output stalls have filled the pipeline, and each block passes through
// every stage whatever the key mode; there is one register stage per round, 64 in all, and
// in 128-bit mode the last 16 stages pass the block through unchanged. Each stage only
// holds while its own result is waiting, so empty slots are squeezed out when the output
// side stalls. Keys and the mode register are written through the plain write port and
// must only change while no block is in flight.
module rtea_block_cipher_64_top
    import rtea_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BLOCK_W-1:0]   i_cfg_data,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_opcode,
    input  logic [BLOCK_W-1:0]   i_block_in,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BLOCK_W-1:0]   o_block_out
);

    t_key_regs r_keys;
    logic      r_long_mode;

    logic  [NUM_STAGES:0] vld;
    logic  [NUM_STAGES:0] en;
    t_item                item [NUM_STAGES+1];

    // Configuration registers; indexes past the mode register are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys      <= '0;
            r_long_mode <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_01: r_keys[0]   <= i_cfg_data;
                CFG_KEY_23: r_keys[1]   <= i_cfg_data;
                CFG_KEY_45: r_keys[2]   <= i_cfg_data;
                CFG_KEY_67: r_keys[3]   <= i_cfg_data;
                CFG_MODE:   r_long_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline entry
    assign vld[0]     = i_in_valid;
    assign item[0].op = i_opcode;
    assign item[0].a  = i_block_in[BLOCK_W-1:HALF_W];
    assign item[0].b  = i_block_in[HALF_W-1:0];

    // A stage loads when it is empty or its item moves on
    assign en[NUM_STAGES] = i_out_ready;

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        assign en[s] = !vld[s+1] || en[s+1];

        rtea_stage u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (en[s]),
            .i_stage     (RND_W'(s)),
            .i_long_mode (r_long_mode),
            .i_keys      (r_keys),
            .i_vld       (vld[s]),
            .i_item      (item[s]),
            .o_vld       (vld[s+1]),
            .o_item      (item[s+1])
        );
    end

    // Handshake and result
    assign o_in_ready  = en[0];
    assign o_out_valid = vld[NUM_STAGES];
    assign o_block_out = {item[NUM_STAGES].a, item[NUM_STAGES].b};

endmodule

// ----- tb/rtea_block_cipher_64_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for rtea_block_cipher_64_top: directed and random blocks under both key modes,
// with every result checked in order against a round-by-round model of the cipher.
// Depends on rtea_pkg and the RTL of rtea_block_cipher_64_top.

// Holds a copy of the key registers and the blocks still expected at the output
class block_ledger;
    logic [3:0][63:0] key_pairs;
    bit               long_key;
    logic [63:0]      expected_blocks[$];
    int unsigned      errors;

    function new();
        key_pairs = '0;
        long_key  = 1'b1;
        errors    = 0;
    endfunction

    // Mirror a register write; indexes past the mode register are dropped
    function void write_reg(logic [rtea_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        if (idx == rtea_pkg::CFG_MODE) begin
            long_key = data[0];
        end else if (idx <= rtea_pkg::CFG_KEY_67) begin
            key_pairs[idx[1:0]] = data;
        end
    endfunction

    function logic [31:0] round_mix(logic [31:0] h);
        return h + ((h << 6) ^ (h >> 8));
    endfunction

    // Even key word sits in the high half of each pair
    function logic [31:0] key_word(int unsigned idx);
        logic [63:0] pair;
        pair = key_pairs[idx >> 1];
        return idx[0] ? pair[31:0] : pair[63:32];
    endfunction

    function logic [63:0] cipher_block(logic op, logic [63:0] blk);
        int unsigned words, rounds, r, rr;
        logic [31:0] a, b, t;
        words  = long_key ? 8 : 4;
        rounds = words * 4 + 32;
        a      = blk[63:32];
        b      = blk[31:0];
        if (op == rtea_pkg::OP_ENC) begin
            for (r = 0; r < rounds; r++) begin
                t = key_word(r & (words - 1)) + r;
                if (r[0]) a += round_mix(b) + t;
                else      b += round_mix(a) + t;
            end
        end else begin
            // rounds run backward, undoing each addition
            for (r = rounds; r > 0; r--) begin
                rr = r - 1;
                t  = key_word(rr & (words - 1)) + rr;
                if (rr[0]) a -= round_mix(b) + t;
                else       b -= round_mix(a) + t;
            end
        end
        return {a, b};
    endfunction

    function void note_block(logic op, logic [63:0] blk);
        expected_blocks.push_back(cipher_block(op, blk));
    endfunction

    function void check_block(logic [63:0] actual);
        logic [63:0] want;
        if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected block_out, expected none, actual %h", $time, actual);
            errors++;
        end else begin
            want = expected_blocks.pop_front();
            if (want !== actual) begin
                $display("%0t: block_out mismatch, expected %h, actual %h",
                         $time, want, actual);
                errors++;
            end
        end
    endfunction

    function int unsigned pending();
        return expected_blocks.size();
    endfunction
endclass

module rtea_block_cipher_64_top_tb;
    import rtea_pkg::*;

    localparam int PIPE_DEPTH       = 64;
    localparam int RANDOM_PHASES    = 6;
    localparam int BLOCKS_PER_PHASE = 260;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [BLOCK_W-1:0]   cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 opcode    = OP_ENC;
    logic [BLOCK_W-1:0]   block_in  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BLOCK_W-1:0]   block_out;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    block_ledger ledger;

    rtea_block_cipher_64_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_opcode    (opcode),
        .i_block_in  (block_in),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_block_out (block_out)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] random64();
        return {$urandom, $urandom};
    endfunction

    // Key pairs lean toward the all-zero and all-one extremes now and then
    function automatic logic [63:0] key_pattern();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return random64();
        endcase
    endfunction

    function automatic logic [63:0] corner_block();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(63);
            default: return ~(64'h1 << $urandom_range(63));
        endcase
    endfunction

    // Result side: check accepted items, then pick next cycle's ready
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) ledger.check_block(block_out);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Present one item after a random gap and hold it until accepted
    task automatic send_block(input logic op, input logic [63:0] blk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        block_in <= blk;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ledger.note_block(op, blk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        ledger.write_reg(idx, data);
    endtask

    // Full key and mode load; indexes past the mode register must have no effect
    task automatic configure(input logic [63:0] k01, input logic [63:0] k23,
                             input logic [63:0] k45, input logic [63:0] k67,
                             input logic [63:0] mode_data);
        int i;
        write_reg(CFG_KEY_01, k01);
        write_reg(CFG_KEY_23, k23);
        write_reg(CFG_KEY_45, k45);
        write_reg(CFG_KEY_67, k67);
        for (i = CFG_MODE + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), random64());
        write_reg(CFG_MODE, mode_data);
        cfg_we <= 1'b0;
    endtask

    // Stop sending and let the pipeline empty before the next key change
    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Field extremes and bit patterns, both directions
    task automatic directed_blocks();
        send_block(OP_ENC, '0);
        send_block(OP_DEC, '0);
        send_block(OP_ENC, '1);
        send_block(OP_DEC, '1);
        send_block(OP_ENC, 64'h8000_0000_0000_0001);
        send_block(OP_DEC, 64'h0000_0001_8000_0000);
        send_block(OP_ENC, 64'h5555_5555_AAAA_AAAA);
        send_block(OP_DEC, 64'hAAAA_AAAA_5555_5555);
    endtask

    initial begin
        int unsigned ph, n;
        logic [63:0] blk, mode_data;
        logic        op;
        ledger = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: long key mode with an all-zero key
        send_block(OP_ENC, '0);
        send_block(OP_DEC, '1);
        send_block(OP_ENC, 64'hFFFF_FFFF_0000_0000);
        drain();

        // all-ones short key; spare words loaded but unused, mode upper bits dropped
        configure('1, '1, random64(), random64(), 64'hFFFF_FFFF_FFFF_FFFE);
        directed_blocks();
        drain();

        // random long key, mode data with junk in the upper bits
        mode_data    = random64();
        mode_data[0] = 1'b1;
        configure(random64(), random64(), random64(), random64(), mode_data);
        directed_blocks();
        drain();

        // random traffic; some items feed back an expected block to mix in round trips
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            send_idle_pct = (ph < 2) ? 9 : (ph < 4) ? 58 : 0;
            recv_idle_pct = (ph < 2) ? 58 : (ph < 4) ? 9 : 0;
            mode_data     = random64();
            mode_data[0]  = ph[0];
            configure(key_pattern(), key_pattern(), key_pattern(), key_pattern(), mode_data);
            for (n = 0; n < BLOCKS_PER_PHASE; n++) begin
                op = $urandom_range(1);
                case ($urandom_range(9))
                    0:       blk = corner_block();
                    1, 2:    blk = (ledger.pending() != 0) ? ledger.expected_blocks[$]
                                                          : random64();
                    default: blk = random64();
                endcase
                send_block(op, blk);
            end
            drain();
        end

        repeat (PIPE_DEPTH + 8) @(posedge clk);
        if (ledger.errors == 0) begin
            $display("rtea_block_cipher_64_top test passed");
        end else begin
            $display("rtea_block_cipher_64_top test failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("rtea_block_cipher_64_top test failed");
        $finish;
    end

endmodule
